### hdl/nfc_pkg.sv
package nfc_pkg;

    localparam int RANGE_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int STEP_W    = 14;
    localparam int GAIN_W    = 16;
    localparam int OUT_W     = 21;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // CORDIC datapath: Q16 millimetres, angle in rad * 2^20.
    localparam int CORDIC_W   = 36;
    localparam int ZW         = 24;
    localparam int ATAN_W     = 20;
    localparam int ATAN_IDX_W = 5;
    localparam int PROD_W     = CORDIC_W + GAIN_W + 1;

    localparam logic [RANGE_W-1:0]        GAIN_Q16    = 16'd39796;
    localparam logic signed [ANGLE_W:0]   PI_Q13      = 17'sd25736;
    localparam logic signed [ANGLE_W:0]   HALF_PI_Q13 = 17'sd12868;
    localparam logic signed [ANGLE_W-1:0] START_RESET = -16'sd25736;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_ANGLE  = 3'd0,
        REG_ANGLE_STEP   = 3'd1,
        REG_REJECT_BELOW = 3'd2,
        REG_MIN_FOLLOW   = 3'd3,
        REG_MAX_FOLLOW   = 3'd4,
        REG_LINEAR_GAIN  = 3'd5,
        REG_TURN_GAIN    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] start_angle;
        logic [STEP_W-1:0]         angle_step;
        logic [RANGE_W-1:0]        reject_below;
        logic [RANGE_W-1:0]        min_follow;
        logic [RANGE_W-1:0]        max_follow;
        logic [GAIN_W-1:0]         linear_gain;
        logic [GAIN_W-1:0]         turn_gain;
    } cfg_t;

    // One finished scan handed from the tracker to the command unit.
    typedef struct packed {
        logic [RANGE_W-1:0]        dist_mm;
        logic signed [ANGLE_W-1:0] angle;
        logic                      found;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROT,
        B_FIX,
        B_MUL_LIN,
        B_MUL_TURN,
        B_RES
    } back_state_t;

    function automatic logic [ATAN_W-1:0] atan_q20(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            5'd20:   v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/nfc_if.sv
interface nfc_sample_if
    import nfc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_mm;
    logic               is_last;

    modport source (output valid, output range_mm, output is_last, input ready);
    modport sink (input valid, input range_mm, input is_last, output ready);
endinterface

interface nfc_cmd_if
    import nfc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] linear_speed;
    logic signed [OUT_W-1:0] turn_rate;

    modport source (output valid, output linear_speed, output turn_rate, input ready);
    modport sink (input valid, input linear_speed, input turn_rate, output ready);
endinterface

### hdl/nfc_front.sv
module nfc_front
    import nfc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      load_start,
    input  logic signed [ANGLE_W-1:0] load_angle,
    nfc_sample_if.sink                sample,
    input  logic                      job_full,
    output logic                      job_push,
    output job_t                      job_data
);

    logic signed [ANGLE_W-1:0] beam_angle_reg;
    logic [RANGE_W-1:0]        near_range_reg;
    logic signed [ANGLE_W-1:0] near_angle_reg;
    logic                      found_reg;

    logic                      accept;
    logic                      take;
    logic signed [ANGLE_W+1:0] beam_sum;
    logic signed [ANGLE_W-1:0] beam_next;

    assign sample.ready = !job_full;
    assign accept       = sample.valid && sample.ready;

    assign take = (sample.range_mm >= cfg.reject_below)
                  && (!found_reg || (sample.range_mm < near_range_reg));

    // The beam angle saturates at the top of its range instead of wrapping.
    assign beam_sum  = (ANGLE_W+2)'(beam_angle_reg) + signed'((ANGLE_W+2)'(cfg.angle_step));
    assign beam_next = (beam_sum > (ANGLE_W+2)'(32767)) ? 16'sd32767 : beam_sum[ANGLE_W-1:0];

    // The closing sample takes part in the search before the scan is handed over.
    assign job_push         = accept && sample.is_last;
    assign job_data.dist_mm = take ? sample.range_mm : near_range_reg;
    assign job_data.angle   = take ? beam_angle_reg : near_angle_reg;
    assign job_data.found   = found_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_angle_reg <= START_RESET;
            near_range_reg <= '0;
            near_angle_reg <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            priority if (load_start)
            begin
                beam_angle_reg <= load_angle;
            end
            else if (accept && sample.is_last)
            begin
                beam_angle_reg <= cfg.start_angle;
                near_range_reg <= '0;
                near_angle_reg <= '0;
                found_reg      <= 1'b0;
            end
            else if (accept)
            begin
                beam_angle_reg <= beam_next;
                if (take)
                begin
                    near_range_reg <= sample.range_mm;
                    near_angle_reg <= beam_angle_reg;
                    found_reg      <= 1'b1;
                end
            end
            else
            begin
                beam_angle_reg <= beam_angle_reg;
            end
        end
    end

endmodule

### hdl/nfc_queue.sv
module nfc_queue
    import nfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic valid,
    output job_t data
);

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### hdl/nfc_back.sv
module nfc_back
    import nfc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_pop,
    nfc_cmd_if.source   cmd
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);

    back_state_t state_reg, state_next;

    logic [CNT_W-1:0]           cnt_reg;
    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [ZW-1:0]       z_reg;
    logic                       flip_reg;
    logic                       found_reg;
    logic signed [CORDIC_W-1:0] xf_reg;
    logic signed [CORDIC_W-1:0] nyf_reg;
    logic                       drive_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [OUT_W-1:0]    lin_reg;
    logic                       out_valid_reg;
    logic signed [OUT_W-1:0]    out_lin_reg;
    logic signed [OUT_W-1:0]    out_turn_reg;

    logic                       slot_free;
    logic                       res_load;
    logic signed [ANGLE_W:0]    a_ext;
    logic signed [ANGLE_W:0]    a_red;
    logic                       a_flip;
    logic [2*RANGE_W-1:0]       x_init;
    logic signed [CORDIC_W-1:0] x_sh;
    logic signed [CORDIC_W-1:0] y_sh;
    logic signed [ZW-1:0]       at;
    logic signed [CORDIC_W-1:0] xf_c;
    logic signed [CORDIC_W-1:0] nyf_c;
    logic signed [CORDIC_W-1:0] min_q16;
    logic signed [CORDIC_W-1:0] max_q16;
    logic signed [CORDIC_W-1:0] mul_a;
    logic signed [GAIN_W:0]     mul_b;
    logic signed [PROD_W-1:0]   prod_c;
    logic signed [OUT_W-1:0]    rounded;

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0]    s;
        logic signed [PROD_W-29:0]   q;
        s = p + PROD_W'(1 << 27);
        q = s[PROD_W-1:28];
        if (q > (PROD_W-28)'(1048575))
        begin
            return 21'sd1048575;
        end
        else if (q < -(PROD_W-28)'(1048576))
        begin
            return -21'sd1048576;
        end
        return q[OUT_W-1:0];
    endfunction

    assign slot_free = !out_valid_reg || cmd.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:     if (job_valid) state_next = B_ROT;
            B_ROT:      if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) state_next = B_FIX;
            B_FIX:      state_next = B_MUL_LIN;
            B_MUL_LIN:  state_next = B_MUL_TURN;
            B_MUL_TURN: state_next = B_RES;
            B_RES:      if (slot_free) state_next = B_IDLE;
            default:    state_next = B_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        job_pop  = (state_reg == B_IDLE) && job_valid;
        res_load = (state_reg == B_RES) && slot_free;
    end

    // Angles past a quarter turn are folded back by pi and the result negated.
    assign a_ext  = (ANGLE_W+1)'(job.angle);
    assign a_flip = (a_ext > HALF_PI_Q13) || (a_ext < -HALF_PI_Q13);
    always_comb
    begin
        priority if (a_ext > HALF_PI_Q13)
        begin
            a_red = a_ext - PI_Q13;
        end
        else if (a_ext < -HALF_PI_Q13)
        begin
            a_red = a_ext + PI_Q13;
        end
        else
        begin
            a_red = a_ext;
        end
    end
    assign x_init = (2*RANGE_W)'(job.dist_mm) * (2*RANGE_W)'(GAIN_Q16);

    assign x_sh = x_reg >>> cnt_reg;
    assign y_sh = y_reg >>> cnt_reg;
    assign at   = signed'(ZW'(atan_q20(ATAN_IDX_W'(cnt_reg))));

    assign xf_c    = flip_reg ? x_reg : -x_reg;
    assign nyf_c   = flip_reg ? y_reg : -y_reg;
    assign min_q16 = signed'(CORDIC_W'({cfg.min_follow, 16'h0000}));
    assign max_q16 = signed'(CORDIC_W'({cfg.max_follow, 16'h0000}));

    // One multiplier serves both commands; an idle operand gives a zero result.
    always_comb
    begin
        if (!drive_reg)
        begin
            mul_a = '0;
        end
        else if (state_reg == B_MUL_LIN)
        begin
            mul_a = xf_reg;
        end
        else
        begin
            mul_a = nyf_reg;
        end
        mul_b = (state_reg == B_MUL_LIN) ? signed'({1'b0, cfg.linear_gain})
                                         : signed'({1'b0, cfg.turn_gain});
    end
    assign prod_c  = mul_a * mul_b;
    assign rounded = round_sat(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (job_pop)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == B_ROT)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    x_reg     <= signed'(CORDIC_W'(x_init));
                    y_reg     <= '0;
                    z_reg     <= {a_red, 7'b0000000};
                    flip_reg  <= a_flip;
                    found_reg <= job.found;
                end
            end
            B_ROT:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + at;
                end
            end
            B_FIX:
            begin
                xf_reg    <= xf_c;
                nyf_reg   <= nyf_c;
                drive_reg <= found_reg && (xf_c > min_q16) && (xf_c < max_q16);
            end
            B_MUL_LIN:
            begin
                prod_reg <= prod_c;
            end
            B_MUL_TURN:
            begin
                lin_reg  <= rounded;
                prod_reg <= prod_c;
            end
            B_RES:
            begin
                if (slot_free)
                begin
                    out_lin_reg  <= lin_reg;
                    out_turn_reg <= rounded;
                end
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign cmd.valid        = out_valid_reg;
    assign cmd.linear_speed = out_lin_reg;
    assign cmd.turn_rate    = out_turn_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_ROT) |-> (cnt_reg <= CNT_W'(CORDIC_STEPS - 1)))
        else $error("CORDIC step counter ran past the last step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && job_valid) |=> (state_reg == B_ROT && cnt_reg == '0))
        else $error("Dequeued scan did not start the rotation at step zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_RES))
        else $error("Command appeared without passing the result state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_RES && !drive_reg) |-> (lin_reg == '0 && prod_reg == '0))
        else $error("Command outside the follow window is not zero");
`endif

endmodule

### hdl/nearest_target_follow_command.sv
// Nearest-target follow command.
// The sample channel takes one range reading per beam (range_mm, is_last);
// a transfer happens when valid and ready are both high. The tracker keeps
// the nearest reading at or above reject_below and its beam angle, one
// sample per cycle while the queue has room. The sample marked is_last
// closes the scan: the scan is queued for the command unit and the tracker
// restarts at start_angle. The command unit rotates the nearest range
// through an iterative CORDIC, one step per cycle, then tests the follow
// window and scales x and y with one shared multiplier; the command is then
// registered onto the cmd channel. A new scan is taken only back in idle,
// so the CORDIC loop bounds the scan rate. The scan queue holds two closed
// scans; samples keep flowing while it has room, so a stalled cmd receiver
// only stops the sample channel once the queue holds two scans, with a
// third one held in the command unit behind the output register.
// Configuration writes go through cfg_we/cfg_index/cfg_data and belong
// between scans; writing start_angle also restarts the beam angle.
// Reset loads the register defaults and empties the tracker and queue.
module nearest_target_follow_command
    import nfc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    nfc_sample_if.sink           sample,
    nfc_cmd_if.source            cmd
);

    cfg_t cfg_reg;
    logic load_start;
    logic job_full;
    logic job_push;
    job_t job_in;
    logic job_valid;
    logic job_pop;
    job_t job_out;

    assign load_start = cfg_we && (cfg_index == REG_START_ANGLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_angle  <= START_RESET;
            cfg_reg.angle_step   <= 14'd36;
            cfg_reg.reject_below <= 16'd250;
            cfg_reg.min_follow   <= 16'd500;
            cfg_reg.max_follow   <= 16'd2000;
            cfg_reg.linear_gain  <= 16'd1229;
            cfg_reg.turn_gain    <= 16'd11059;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_ANGLE:  cfg_reg.start_angle  <= signed'(cfg_data);
                REG_ANGLE_STEP:   cfg_reg.angle_step   <= cfg_data[STEP_W-1:0];
                REG_REJECT_BELOW: cfg_reg.reject_below <= cfg_data;
                REG_MIN_FOLLOW:   cfg_reg.min_follow   <= cfg_data;
                REG_MAX_FOLLOW:   cfg_reg.max_follow   <= cfg_data;
                REG_LINEAR_GAIN:  cfg_reg.linear_gain  <= cfg_data;
                REG_TURN_GAIN:    cfg_reg.turn_gain    <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    nfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .load_start (load_start),
        .load_angle (signed'(cfg_data)),
        .sample     (sample),
        .job_full   (job_full),
        .job_push   (job_push),
        .job_data   (job_in)
    );

    nfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .valid     (job_valid),
        .data      (job_out)
    );

    nfc_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .cmd       (cmd)
    );

endmodule

### tb/nfc_checker.sv
module nfc_checker
    import nfc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    nfc_sample_if                sample,
    nfc_cmd_if                   cmd,
    output int                   pending,
    output int                   fails
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     HALF_TURN    = 25736;
    localparam int     QUARTER_TURN = 12868;
    localparam int     BEAM_CEIL    = 32767;
    localparam longint START_GAIN   = 39796;
    localparam longint ROUND_HALF   = longint'(1) <<< 27;
    localparam longint OUT_HI       = 1048575;
    localparam longint OUT_LO       = -1048576;
    localparam int     ATAN_LEN     = 24;
    localparam int     ATAN_RAD20 [ATAN_LEN] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0, 0, 0
    };

    typedef struct packed {
        logic signed [OUT_W-1:0] linear_speed;
        logic signed [OUT_W-1:0] turn_rate;
    } drive_cmd_t;

    drive_cmd_t cmd_due [$];

    logic signed [ANGLE_W-1:0] start_ang;
    logic [STEP_W-1:0]         ang_step;
    logic [RANGE_W-1:0]        reject_lo;
    logic [RANGE_W-1:0]        min_fw;
    logic [RANGE_W-1:0]        max_fw;
    logic [GAIN_W-1:0]         lin_gain;
    logic [GAIN_W-1:0]         turn_gain;

    int                 beam_ang;
    logic [RANGE_W-1:0] near_mm;
    int                 near_ang;
    bit                 seen;
    int                 fail_cnt;

    function automatic longint clamp_out(input longint v);
        if (v > OUT_HI) return OUT_HI;
        if (v < OUT_LO) return OUT_LO;
        return v;
    endfunction

    // d*cos(a) and d*sin(a) in Q16 mm; angles past a quarter turn are folded
    // by half a turn and the vector is negated afterwards.
    function automatic void rotate_range(input longint d, input int a,
                                         output longint c, output longint s);
        longint x, y, z, nx;
        bit     flip;
        flip = 1'b0;
        if (a > QUARTER_TURN) begin
            a = a - HALF_TURN;
            flip = 1'b1;
        end
        else if (a < -QUARTER_TURN) begin
            a = a + HALF_TURN;
            flip = 1'b1;
        end
        x = d * START_GAIN;
        y = 0;
        z = longint'(a) * 128;
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_RAD20[i];
            end
            else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_RAD20[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic drive_cmd_t follow_command(input logic [RANGE_W-1:0] d, input int a,
                                                  input bit found);
        drive_cmd_t r;
        longint     c, s, x, y, lin, turn;
        lin  = 0;
        turn = 0;
        if (found) begin
            rotate_range(longint'(d), a, c, s);
            x = -c;
            y = s;
            if (x > (longint'(min_fw) <<< 16) && x < (longint'(max_fw) <<< 16)) begin
                lin  = clamp_out((x * longint'(lin_gain) + ROUND_HALF) >>> 28);
                turn = clamp_out((-y * longint'(turn_gain) + ROUND_HALF) >>> 28);
            end
        end
        r.linear_speed = lin[OUT_W-1:0];
        r.turn_rate    = turn[OUT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        drive_cmd_t         want;
        logic [RANGE_W-1:0] rng;
        int                 nxt;
        if (!rst_n) begin
            start_ang = -16'sd25736;
            ang_step  = 14'd36;
            reject_lo = 16'd250;
            min_fw    = 16'd500;
            max_fw    = 16'd2000;
            lin_gain  = 16'd1229;
            turn_gain = 16'd11059;
            beam_ang  = start_ang;
            near_mm   = '0;
            near_ang  = 0;
            seen      = 1'b0;
            fail_cnt  = 0;
            cmd_due.delete();
            pending <= 0;
            fails   <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_START_ANGLE: begin
                        start_ang = cfg_data;
                        beam_ang  = start_ang;
                    end
                    REG_ANGLE_STEP:   ang_step  = cfg_data[STEP_W-1:0];
                    REG_REJECT_BELOW: reject_lo = cfg_data;
                    REG_MIN_FOLLOW:   min_fw    = cfg_data;
                    REG_MAX_FOLLOW:   max_fw    = cfg_data;
                    REG_LINEAR_GAIN:  lin_gain  = cfg_data;
                    REG_TURN_GAIN:    turn_gain = cfg_data;
                    default: ;
                endcase
            end

            // Check the outgoing command before a closing sample in the same
            // cycle queues a new one.
            if (cmd.valid && cmd.ready) begin
                if (cmd_due.size() == 0) begin
                    $error("command transfer with no scan closed: linear_speed %0d, turn_rate %0d",
                           cmd.linear_speed, cmd.turn_rate);
                    fail_cnt++;
                end
                else begin
                    want = cmd_due.pop_front();
                    if (cmd.linear_speed !== want.linear_speed) begin
                        $error("linear_speed: expected %0d, got %0d",
                               want.linear_speed, cmd.linear_speed);
                        fail_cnt++;
                    end
                    if (cmd.turn_rate !== want.turn_rate) begin
                        $error("turn_rate: expected %0d, got %0d",
                               want.turn_rate, cmd.turn_rate);
                        fail_cnt++;
                    end
                end
            end

            if (sample.valid && sample.ready) begin
                rng = sample.range_mm;
                if (rng >= reject_lo && (!seen || rng < near_mm)) begin
                    near_mm  = rng;
                    near_ang = beam_ang;
                    seen     = 1'b1;
                end
                if (!sample.is_last) begin
                    nxt = beam_ang + int'(ang_step);
                    beam_ang = (nxt > BEAM_CEIL) ? BEAM_CEIL : nxt;
                end
                else begin
                    cmd_due.push_back(follow_command(near_mm, near_ang, seen));
                    near_mm  = '0;
                    near_ang = 0;
                    seen     = 1'b0;
                    beam_ang = start_ang;
                end
            end

            pending <= cmd_due.size();
            fails   <= fail_cnt;
        end
    end

endmodule

### tb/nearest_target_follow_command_test.sv
module nearest_target_follow_command_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nfc_pkg::*;

    localparam int STEPS           = 16;
    localparam int TAIL_CYCLES     = STEPS + 16;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 70;

    // Index past the register list; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    int snd_idle_pct;
    int rcv_idle_pct;
    bit stall_req;
    bit stall_taken;
    int stall_left;
    int pending;
    int fails;

    nfc_sample_if smp_ch();
    nfc_cmd_if    cmd_ch();

    nearest_target_follow_command #(.CORDIC_STEPS(STEPS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (smp_ch),
        .cmd       (cmd_ch)
    );

    nfc_checker #(.CORDIC_STEPS(STEPS)) chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (smp_ch),
        .cmd       (cmd_ch),
        .pending   (pending),
        .fails     (fails)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    // Command receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_ch.ready <= 1'b0;
            stall_left   <= 0;
            stall_taken  <= 1'b0;
        end
        else if (stall_req && !stall_taken) begin
            stall_taken  <= 1'b1;
            stall_left   <= HOLD_CYCLES;
            cmd_ch.ready <= 1'b0;
        end
        else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            cmd_ch.ready <= 1'b0;
        end
        else begin
            cmd_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Valid stays high on return so the next sample can follow back to back.
    task automatic send_sample(input logic [RANGE_W-1:0] r, input bit last);
        while ($urandom_range(99) < snd_idle_pct) begin
            smp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        smp_ch.valid    <= 1'b1;
        smp_ch.range_mm <= r;
        smp_ch.is_last  <= last;
        @(posedge clk);
        while (!smp_ch.ready) @(posedge clk);
    endtask

    task automatic settle();
        smp_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t s);
        logic [CFG_DAT_W-1:0] junk;
        junk = 16'($urandom);
        write_reg(REG_START_ANGLE, s.start_angle);
        // The upper bits of the step write lie outside the register.
        write_reg(REG_ANGLE_STEP, {junk[1:0], s.angle_step});
        write_reg(REG_REJECT_BELOW, s.reject_below);
        write_reg(REG_MIN_FOLLOW, s.min_follow);
        write_reg(REG_MAX_FOLLOW, s.max_follow);
        write_reg(REG_LINEAR_GAIN, s.linear_gain);
        write_reg(REG_TURN_GAIN, s.turn_gain);
        write_reg(REG_NONE, junk);
        cfg_we <= 1'b0;
    endtask

    function automatic cfg_t draw_settings();
        cfg_t s;
        int   pick;
        int   tmp;
        pick = $urandom_range(19);
        if (pick < 14)
            s.start_angle = 16'(int'($urandom_range(51472)) - 25736);
        else if (pick < 17)
            s.start_angle = 16'(int'($urandom_range(400)) - 25736);
        else
            s.start_angle = 16'($urandom);
        pick = $urandom_range(9);
        if (pick < 6)
            s.angle_step = 14'($urandom_range(200));
        else if (pick < 8)
            s.angle_step = 14'($urandom_range(8192));
        else
            s.angle_step = 14'($urandom);
        pick = $urandom_range(9);
        if (pick < 7)
            s.reject_below = 16'($urandom_range(600));
        else if (pick < 9)
            s.reject_below = 16'($urandom);
        else
            s.reject_below = '0;
        pick = $urandom_range(9);
        if (pick < 8)
            s.min_follow = 16'($urandom_range(2000));
        else if (pick < 9)
            s.min_follow = '0;
        else
            s.min_follow = 16'($urandom);
        pick = $urandom_range(19);
        tmp = int'(s.min_follow) + int'($urandom_range(4000));
        if (pick < 17)
            s.max_follow = (tmp > 65535) ? 16'hFFFF : 16'(tmp);
        else if (pick < 19)
            s.max_follow = 16'hFFFF;
        else
            s.max_follow = 16'($urandom);
        pick = $urandom_range(9);
        s.linear_gain = (pick < 8) ? 16'($urandom) : (pick < 9) ? 16'h0000 : 16'hFFFF;
        pick = $urandom_range(9);
        s.turn_gain = (pick < 8) ? 16'($urandom) : (pick < 9) ? 16'h0000 : 16'hFFFF;
        return s;
    endfunction

    // One scan: mostly ranges near the follow window, with rejects, repeats
    // for ties, and full-scale values mixed in.
    task automatic random_scan(input int len);
        logic [RANGE_W-1:0] r;
        logic [RANGE_W-1:0] prev;
        prev = 16'($urandom_range(3000));
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: r = 16'($urandom_range(3000));
                5, 6:          r = 16'($urandom);
                7:             r = 16'($urandom_range(300));
                8:             r = prev;
                default:       r = (k % 2 != 0) ? 16'hFFFF : 16'h0000;
            endcase
            send_sample(r, k == len - 1);
            prev = r;
        end
    endtask

    initial begin
        cfg_t s;
        int   len;
        int   items;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_START_ANGLE;
        cfg_data        <= '0;
        smp_ch.valid    <= 1'b0;
        smp_ch.range_mm <= '0;
        smp_ch.is_last  <= 1'b0;
        rcv_idle_pct    <= 0;
        snd_idle_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: nothing accepted, reject edge, out of window,
        // a tie, and the closing sample being the nearest.
        send_sample(16'd0, 1'b1);
        send_sample(16'd249, 1'b0);
        send_sample(16'd250, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'd1000, 1'b0);
        send_sample(16'd800, 1'b0);
        send_sample(16'd800, 1'b0);
        send_sample(16'd1500, 1'b1);
        send_sample(16'd1500, 1'b0);
        send_sample(16'd900, 1'b1);
        settle();

        s = '{start_angle: 16'sh8000, angle_step: 14'h3FFF, reject_below: 16'h0000,
              min_follow: 16'h0000, max_follow: 16'hFFFF, linear_gain: 16'hFFFF,
              turn_gain: 16'hFFFF};
        load_settings(s);
        send_sample(16'd30000, 1'b0);
        send_sample(16'd20000, 1'b0);
        send_sample(16'd10000, 1'b1);
        send_sample(16'd5000, 1'b1);
        settle();

        // Starting at half a turn with a large step drives the beam angle
        // into saturation.
        s = '{start_angle: 16'sd25736, angle_step: 14'd8192, reject_below: 16'd100,
              min_follow: 16'd100, max_follow: 16'd60000, linear_gain: 16'd4096,
              turn_gain: 16'd4096};
        load_settings(s);
        send_sample(16'd3000, 1'b0);
        send_sample(16'd2000, 1'b0);
        send_sample(16'd1000, 1'b1);
        send_sample(16'd1000, 1'b1);
        settle();

        s = '{start_angle: 16'sd32767, angle_step: 14'd0, reject_below: 16'hFFFF,
              min_follow: 16'hFFFF, max_follow: 16'h0000, linear_gain: 16'h0000,
              turn_gain: 16'h0000};
        load_settings(s);
        send_sample(16'd65534, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        settle();

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct <= 0;
                end
                1: begin
                    snd_idle_pct = 71;
                    rcv_idle_pct <= 0;
                end
                2: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct <= 71;
                end
                default: begin
                    snd_idle_pct = 28;
                    rcv_idle_pct <= 28;
                end
            endcase
            for (int ph = 0; ph < 3; ph++) begin
                load_settings(draw_settings());
                items = 0;
                while (items < ITEMS_PER_PHASE) begin
                    if ($urandom_range(9) == 0)
                        len = $urandom_range(40, 13);
                    else
                        len = $urandom_range(12, 1);
                    random_scan(len);
                    items += len;
                end
                settle();
            end
        end

        // Long receiver hold-off while short scans keep coming, so the scan
        // queue fills and the sample channel stops taking transfers.
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        load_settings(draw_settings());
        stall_req <= 1'b1;
        for (int n = 0; n < 12; n++)
            random_scan($urandom_range(2, 1));
        settle();

        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
hdl/nfc_pkg.sv
hdl/nfc_if.sv
hdl/nfc_front.sv
hdl/nfc_queue.sv
hdl/nfc_back.sv
hdl/nearest_target_follow_command.sv
tb/nfc_checker.sv
tb/nearest_target_follow_command_test.sv
